// ===== rtl/srpq_pkg.sv =====
// ----------------------------------------------------------------------------
// srpq_pkg
// Shared types and constants of the sorted ring priority queue.
// ----------------------------------------------------------------------------
package srpq_pkg;

  localparam int DEPTH   = 16;
  localparam int NCELLS  = DEPTH - 1;
  localparam int CNT_W   = $clog2(DEPTH);
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 4;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/srpq_cell.sv =====
// ----------------------------------------------------------------------------
// srpq_cell
// One slot of the sorted chain: holds a key, compares it against the
// incoming key and takes its neighbor's key on an insert or a removal.
// ----------------------------------------------------------------------------
module srpq_cell
  import srpq_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             occupied,
  input  logic [KEY_W-1:0] left_key,
  input  logic             left_ge,
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key_q,
  output logic             ge
);

  // an empty slot counts as not smaller, so the insert point is the first ge
  assign ge = !occupied || (key_q >= ctrl.key);

  always_ff @(posedge clk) begin
    if (ctrl.push && ge) begin
      key_q <= left_ge ? left_key : ctrl.key;
    end else if (ctrl.pop) begin
      key_q <= right_key;
    end
  end

endmodule

// ===== rtl/sorted_ring_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue
// Min-priority queue of unsigned keys kept sorted in a chain of cells,
// smallest key in cell 0. Push inserts in front of the first key that is
// not smaller, pop removes cell 0 and shifts the chain down.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------
//  command  | start / busy       | opcode, key
//  result   | done (strobe)      | popped_key, status, count
//
// one beat per cycle: every cell compares and shifts in the same cycle,
// so a command is taken every cycle and busy stays low.
// the result strobe is registered and comes in the cycle after the command beat.
// rst (synchronous) empties the queue; key storage is not cleared.
// the receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue
  import srpq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [KEY_W-1:0]   key,
  output logic               done,
  output logic [KEY_W-1:0]   popped_key,
  output logic [1:0]         status,
  output logic [COUNT_W-1:0] count
);

  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [KEY_W-1:0]         cell_key [NCELLS];
  logic [NCELLS-1:0]        cell_ge;
  logic                     is_full;
  logic                     is_empty;
  logic                     take;
  cell_ctrl_t               ctrl;
  status_t                  st_next;
  logic [KEY_W-1:0]         popped_next;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign is_full  = (cnt == CNT_W'(NCELLS));
  assign is_empty = (cnt == '0);

  always_comb begin
    ctrl.push   = 1'b0;
    ctrl.pop    = 1'b0;
    ctrl.key    = key;
    st_next     = ST_OK;
    popped_next = '0;
    cnt_next    = cnt;
    if (take) begin
      unique case (opcode_t'(opcode))
        OP_PUSH: begin
          if (is_full) begin
            st_next = ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            cnt_next  = cnt + 1'b1;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            st_next = ST_EMPTY;
          end else begin
            ctrl.pop    = 1'b1;
            popped_next = cell_key[0];
            cnt_next    = cnt - 1'b1;
          end
        end
        default: st_next = ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic             left_ge;
    logic [KEY_W-1:0] right_key;
    logic             occupied;

    assign occupied = (CNT_W'(i) < cnt);
    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_ge  = cell_ge[i-1];
    end
    if (i == NCELLS - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    srpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occupied),
      .left_key  (left_key),
      .left_ge   (left_ge),
      .right_key (right_key),
      .key_q     (cell_key[i]),
      .ge        (cell_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= take;
    end
  end

  always_ff @(posedge clk) begin
    popped_key <= popped_next;
    status     <= st_next;
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt};
  assign count   = cnt_ext[COUNT_W-1:0];

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NCELLS))
    else $error("queue holds more keys than cells");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> done)
    else $error("command beat without result strobe");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (cnt >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
    else $error("head of chain out of order");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (take && ctrl.pop) |=> (cnt == $past(cnt) - 1'b1))
    else $error("pop did not remove one key");
`endif

endmodule
